### hdl/hrcd_pkg.sv
// shared types, constants and keyword table for the request completion detector
package hrcd_pkg;

    localparam int unsigned LEN_W  = 31;
    localparam int unsigned KW_LEN = 15;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // number parse phases
    localparam logic [1:0] PH_KEY   = 2'd0;
    localparam logic [1:0] PH_BLANK = 2'd1;
    localparam logic [1:0] PH_NUM   = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_C     = 8'h43;

    typedef struct packed {
        logic             status;
        logic             header_done;
        logic [LEN_W-1:0] content_length;
        logic [LEN_W-1:0] body_bytes;
    } t_result;

    // "Content-Length:" one character per index
    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/hrcd_parse.sv
// parse state registers and the single-byte update logic
module hrcd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_new,
    output hrcd_pkg::t_result o_res
);
    import hrcd_pkg::*;

    logic [1:0]       r_term,  n_term;
    logic             r_hdone, n_hdone;
    logic [3:0]       r_kw,    n_kw;
    logic [1:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_val,   n_val;
    logic             r_neg,   n_neg;
    logic [LEN_W-1:0] r_body,  n_body;

    logic [LEN_W-1:0] val_base;
    logic [LEN_W+3:0] prod;
    logic [LEN_W-1:0] len;
    logic             is_digit;
    logic             take_digit;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // value before this byte, cleared on a new request
    assign val_base = i_new ? '0 : r_val;
    // value * 10 + digit; the low nibble of an ascii digit is its value
    assign prod = {3'b000, val_base, 1'b0}
                + {1'b0, val_base, 3'b000}
                + {{LEN_W{1'b0}}, i_byte[3:0]};

    always_comb begin
        n_term     = i_new ? '0 : r_term;
        n_hdone    = i_new ? 1'b0 : r_hdone;
        n_kw       = i_new ? '0 : r_kw;
        n_phase    = i_new ? PH_KEY : r_phase;
        n_val      = val_base;
        n_neg      = i_new ? 1'b0 : r_neg;
        n_body     = i_new ? '0 : r_body;
        take_digit = 1'b0;

        if (n_hdone) begin
            if (n_body != LEN_MAX) begin
                n_body = n_body + 1'b1;
            end
        end else begin
            // keyword and number
            if (n_phase == PH_KEY) begin
                if ((n_kw < 4'(KW_LEN)) && (i_byte == kw_char(n_kw))) begin
                    if (n_kw == 4'(KW_LEN - 1)) begin
                        n_phase = PH_BLANK;
                    end
                    n_kw = n_kw + 1'b1;
                end else begin
                    n_kw = (i_byte == CH_C) ? 4'd1 : 4'd0;
                end
            end else if (n_phase == PH_BLANK) begin
                if ((i_byte == CH_SP) || (i_byte == CH_TAB)) begin
                    n_phase = PH_BLANK;
                end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                    // sign takes this byte, digits start with the next
                    n_neg   = (i_byte == CH_MINUS);
                    n_phase = PH_NUM;
                end else begin
                    n_phase    = PH_NUM;
                    take_digit = 1'b1;
                end
            end else if (n_phase == PH_NUM) begin
                take_digit = 1'b1;
            end
            if (take_digit) begin
                if (is_digit) begin
                    n_val = (prod[LEN_W+3:LEN_W] != '0) ? LEN_MAX : prod[LEN_W-1:0];
                end else begin
                    n_phase = PH_DONE;
                end
            end
            // header terminator
            case (n_term)
                2'd0, 2'd2: begin
                    n_term = (i_byte == CH_CR) ? n_term + 1'b1 : 2'd0;
                end
                default: begin
                    if (i_byte == CH_LF) begin
                        if (n_term == 2'd3) begin
                            n_hdone = 1'b1;
                            n_term  = 2'd0;
                        end else begin
                            n_term = 2'd2;
                        end
                    end else begin
                        n_term = (i_byte == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end
    end

    assign len                  = n_neg ? '0 : n_val;
    assign o_res.status         = n_hdone && (n_body >= len);
    assign o_res.header_done    = n_hdone;
    assign o_res.content_length = len;
    assign o_res.body_bytes     = n_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term  <= '0;
            r_hdone <= 1'b0;
            r_kw    <= '0;
            r_phase <= PH_KEY;
            r_val   <= '0;
            r_neg   <= 1'b0;
            r_body  <= '0;
        end else if (i_step) begin
            r_term  <= n_term;
            r_hdone <= n_hdone;
            r_kw    <= n_kw;
            r_phase <= n_phase;
            r_val   <= n_val;
            r_neg   <= n_neg;
            r_body  <= n_body;
        end
    end

endmodule

### hdl/http_request_completion_detector.sv
// top level: input register, parse update and result register
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_ready  i_data_byte, i_new_request
//  result   out        o_valid / i_ready  o_status, o_header_done,
//                                         o_content_length, o_body_bytes
//
// one byte per cycle sustained while the result side is ready; each byte passes the
// input register, then the parse update into the result register
// the parse state registers are updated in the same cycle the result is registered
// synchronous active-low reset clears both valid flags and all parse state
// a stalled result holds the pipe; the input register still takes one more byte
module http_request_completion_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_new_request,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_status,
    output logic                       o_header_done,
    output logic [hrcd_pkg::LEN_W-1:0] o_content_length,
    output logic [hrcd_pkg::LEN_W-1:0] o_body_bytes
);
    import hrcd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_new;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result res;

    logic step;     // byte in the input register moves into the result register
    logic out_free; // result register can be loaded this cycle

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_new  <= i_new_request;
        end
    end

    // parse state and byte update
    hrcd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_new   (r_in_new),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_header_done    = r_out.header_done;
    assign o_content_length = r_out.content_length;
    assign o_body_bytes     = r_out.body_bytes;

    // a complete request always has its header ended
    a_status_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_header_done)
        else $error("status set without header end");

    // a complete request has at least the announced body
    a_status_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_body_bytes >= o_content_length)
        else $error("status set with short body");

    // a byte moved out of the input register shows up as a result
    a_step_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("stepped byte lost");

    // input side only stalls when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input stalled with room");

endmodule

### dv/http_request_completion_detector_test.sv
// self-checking testbench for the http request completion detector
`timescale 1ns / 100ps

module http_request_completion_detector_test;
    import hrcd_pkg::*;

    // generous bound: every byte waiting out the longest sender gap and sink stall, several times
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PRINT_CAP   = 50;
    localparam logic [8*KW_LEN-1:0] KEYWORD_TEXT = "Content-Length:";

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_data_byte   = 8'h00;
    logic                 i_new_request = 1'b0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic                 o_status;
    logic                 o_header_done;
    logic [LEN_W-1:0]     o_content_length;
    logic [LEN_W-1:0]     o_body_bytes;

    // predicted parse state, mirrors the block after each accepted byte
    logic [2:0]           crlf_seen     = '0;
    logic                 hdr_seen      = 1'b0;
    logic [3:0]           kw_matched    = '0;
    logic [1:0]           len_phase     = PH_KEY;
    logic [LEN_W-1:0]     len_val       = '0;
    logic                 len_neg       = 1'b0;
    logic [LEN_W-1:0]     body_cnt      = '0;

    t_result              awaited_status[$];
    t_result              head_status;
    logic [7:0]           req_bytes[$];
    int unsigned          items_sent     = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    bit                   src_idle_on    = 1'b1;
    bit                   sink_idle_on   = 1'b1;

    http_request_completion_detector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_new_request    (i_new_request),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_header_done    (o_header_done),
        .o_content_length (o_content_length),
        .o_body_bytes     (o_body_bytes)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_status.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // completion predictor: advances the mirrored state by one byte and
    // returns the status the block should report for it
    // ------------------------------------------------------------------
    function automatic t_result predict_status(input logic [7:0] b, input logic fresh);
        t_result          r;
        logic [63:0]      acc;
        logic [LEN_W-1:0] len;
        bit               take_digit;
        take_digit = 1'b0;
        if (fresh) begin
            crlf_seen  = '0;
            hdr_seen   = 1'b0;
            kw_matched = '0;
            len_phase  = PH_KEY;
            len_val    = '0;
            len_neg    = 1'b0;
            body_cnt   = '0;
        end
        if (hdr_seen) begin
            // body byte, count saturates at the top of the 31-bit range
            if (body_cnt != LEN_MAX)
                body_cnt = body_cnt + 1'b1;
        end else begin
            // keyword match, then blanks, optional sign and digits
            if (len_phase == PH_KEY) begin
                if (b == KEYWORD_TEXT[8*(KW_LEN-1-kw_matched) +: 8]) begin
                    kw_matched = kw_matched + 1'b1;
                    if (kw_matched == KW_LEN)
                        len_phase = PH_BLANK;
                end else begin
                    kw_matched = (b == CH_C) ? 4'd1 : 4'd0;
                end
            end else if (len_phase == PH_BLANK) begin
                if (b == CH_PLUS || b == CH_MINUS) begin
                    len_neg   = (b == CH_MINUS);
                    len_phase = PH_NUM;
                end else if (b != CH_SP && b != CH_TAB) begin
                    len_phase  = PH_NUM;
                    take_digit = 1'b1;
                end
            end else if (len_phase == PH_NUM) begin
                take_digit = 1'b1;
            end
            if (take_digit) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    acc = 64'(len_val) * 64'd10 + 64'(b - CH_ZERO);
                    len_val = (acc > 64'(LEN_MAX)) ? LEN_MAX : acc[LEN_W-1:0];
                end else begin
                    len_phase = PH_DONE;
                end
            end
            // blank line detection, the final lf still belongs to the header
            if (crlf_seen == 3'd0 || crlf_seen == 3'd2) begin
                crlf_seen = (b == CH_CR) ? crlf_seen + 3'd1 : 3'd0;
            end else if (b == CH_LF) begin
                if (crlf_seen == 3'd3) begin
                    hdr_seen  = 1'b1;
                    crlf_seen = 3'd0;
                end else begin
                    crlf_seen = 3'd2;
                end
            end else begin
                crlf_seen = (b == CH_CR) ? 3'd1 : 3'd0;
            end
        end
        len = len_neg ? '0 : len_val;
        r.status         = hdr_seen && (body_cnt >= len);
        r.header_done    = hdr_seen;
        r.content_length = len;
        r.body_bytes     = body_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // a result transaction completes on a rising edge with o_valid and i_ready high
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_status.size() == 0) begin
                report_mismatch("result with nothing outstanding, body_bytes", o_body_bytes, 0);
            end else begin
                head_status = awaited_status.pop_front();
                if (o_status !== head_status.status)
                    report_mismatch("status", o_status, head_status.status);
                if (o_header_done !== head_status.header_done)
                    report_mismatch("header_done", o_header_done, head_status.header_done);
                if (o_content_length !== head_status.content_length)
                    report_mismatch("content_length", o_content_length,
                                    head_status.content_length);
                if (o_body_bytes !== head_status.body_bytes)
                    report_mismatch("body_bytes", o_body_bytes, head_status.body_bytes);
            end
        end
    end

    // ------------------------------------------------------------------
    // idle pattern shared by both sides: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 48);
    endfunction

    // result sink, i_ready changes on the falling edge only
    initial begin : sink_driver
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            stall = sink_idle_on ? idle_gap() : 0;
            if (stall != 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // byte transactions, always entered just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fresh);
        int unsigned gap;
        gap = src_idle_on ? idle_gap() : 0;
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_data_byte   = b;
        i_new_request = fresh;
        do @(posedge i_clk); while (!o_ready);
        awaited_status.push_back(predict_status(b, fresh));
        items_sent++;
        @(negedge i_clk);
    endtask

    // holds the input back until every outstanding result has been seen
    task automatic wait_drained();
        i_valid = 1'b0;
        while (awaited_status.size() != 0)
            @(negedge i_clk);
    endtask

    // the first byte may open a new request, later ones now and then restart it
    task automatic send_request(input logic fresh);
        foreach (req_bytes[k])
            send_byte(req_bytes[k], (k == 0) ? fresh : ($urandom_range(0, 149) == 0));
    endtask

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            req_bytes.push_back(s[k]);
    endfunction

    function automatic void add_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    // bytes biased towards the ones the parser reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_C;
            3:       return ":";
            4:       return CH_ZERO + 8'($urandom_range(0, 9));
            5:       return CH_SP;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // header lines, some of them near misses of the keyword
    function automatic string filler_line();
        case ($urandom_range(0, 4))
            0:       return "Host: h";
            1:       return "Content-Len: 5";
            2:       return "content-length: 8";
            3:       return "Content-Length 6";
            default: return "X-Content-Length: 2";
        endcase
    endfunction

    task automatic build_random_request();
        int unsigned kind;
        int unsigned pick;
        kind = $urandom_range(0, 99);
        req_bytes.delete();
        if (kind < 15) begin
            repeat ($urandom_range(1, 24)) req_bytes.push_back(noise_byte());
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            add_text(filler_line());
            add_crlf();
        end
        if (kind < 85) begin
            // a stray leading c checks that a partial match restarts on c
            if ($urandom_range(0, 4) == 0)
                add_text("C");
            add_text("Content-Length:");
            repeat ($urandom_range(0, 2))
                req_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
            case ($urandom_range(0, 9))
                0:       req_bytes.push_back(CH_PLUS);
                1:       req_bytes.push_back(CH_MINUS);
                default: ;
            endcase
            pick = $urandom_range(0, 99);
            if (pick >= 4 && pick < 88)
                add_text($sformatf("%0d", $urandom_range(0, 20)));
            else if (pick >= 88 && pick < 94)
                add_text($sformatf("%0d", $urandom()));
            else if (pick >= 94) begin
                case ($urandom_range(0, 2))
                    0:       add_text("2147483647");
                    1:       add_text("2147483648");
                    default: add_text("00099999999999");
                endcase
            end
            // digits after the number has ended are ignored
            if ($urandom_range(0, 4) == 0)
                add_text(" 7");
            add_crlf();
            // only the first keyword in the header counts
            if ($urandom_range(0, 4) == 0) begin
                add_text("Content-Length: 9");
                add_crlf();
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            add_text(filler_line());
            add_crlf();
        end
        add_crlf();
        repeat ($urandom_range(0, 12)) req_bytes.push_back(noise_byte());
        if ($urandom_range(0, 5) == 0)
            add_text("Content-Length: 1");
        // cut short now and then so a request ends mid-way
        if ($urandom_range(0, 9) == 0 && req_bytes.size() > 1)
            repeat ($urandom_range(1, req_bytes.size() - 1)) void'(req_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_byte_extremes();
        // all-zero and all-one bytes around a bare blank line, length zero
        req_bytes = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_CR, CH_LF, 8'hFF, 8'h00};
        send_request(1'b1);
    endtask

    task automatic test_sign_and_blanks();
        // tab before a minus sign gives length zero
        req_bytes.delete();
        add_text("Content-Length:\t-4");
        add_crlf();
        add_crlf();
        add_text("z");
        send_request(1'b1);
        // line break straight after the keyword, no digits
        req_bytes.delete();
        add_text("Content-Length:");
        add_crlf();
        add_crlf();
        add_text("q");
        send_request(1'b1);
    endtask

    task automatic test_length_saturation();
        req_bytes.delete();
        add_text("Content-Length: 99999999999");
        add_crlf();
        add_crlf();
        add_text("x");
        send_request(1'b1);
    endtask

    task automatic test_keyword_after_header();
        // keyword in the body must not set a length
        req_bytes.delete();
        add_crlf();
        add_crlf();
        add_text("Content-Length: 9");
        send_request(1'b1);
    endtask

    task automatic test_random_requests();
        int unsigned target;
        int unsigned req_count;
        target    = items_sent + 1100;
        req_count = 0;
        while (items_sent < target) begin
            // switch idling on and off so some stretches run flat out
            if ($urandom_range(0, 7) == 0) begin
                src_idle_on  = $urandom_range(0, 1);
                sink_idle_on = $urandom_range(0, 1);
            end
            build_random_request();
            send_request($urandom_range(0, 9) != 0);
            req_count++;
            if (req_count % 8 == 0)
                wait_drained();
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_byte_extremes();
        test_sign_and_blanks();
        test_length_saturation();
        test_keyword_after_header();
        wait_drained();
        test_random_requests();
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### http_request_completion_detector.f
hdl/hrcd_pkg.sv
hdl/hrcd_parse.sv
hdl/http_request_completion_detector.sv
dv/http_request_completion_detector_test.sv
